FILE: hw/rtl/slwc_pkg.sv
// ----------------------------------------------------------------------------
// slwc_pkg - shared types and constants
// Field widths, codes and defaults for the set-associative LRU write-back
// cache tag model.
// ----------------------------------------------------------------------------
package slwc_pkg;

  // default sizing, overridable on the top level
  localparam int MAX_SET_BITS_DEF = 10;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDRESS_BITS_DEF = 32;

  // fixed word field widths
  localparam int ADDR_FIELD_W = 32;
  localparam int SIZE_W       = 8;
  localparam int TAG_FIELD_W  = 32;
  localparam int SET_FIELD_W  = 10;
  localparam int OFF_W        = 8;
  localparam int HITS_W       = 32;
  localparam int MACC_W       = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_DATA_W-1:0] SET_BITS_RST = 4'd0;
  localparam logic [CFG_DATA_W-1:0] OFF_BITS_RST = 4'd3;
  localparam logic [CFG_DATA_W-1:0] WAYS_RST     = 4'd1;

  // clamped geometry widths (sets up to 16 bits, ways up to 16)
  localparam int SHIFT_W       = 5;
  localparam int WAYS_W        = 5;
  localparam int LINE_BITS_TOP = 8;

  // recency rank, 0 is most recent
  localparam int RANK_W = 3;
  localparam logic [RANK_W-1:0] RANK_TOP = 3'd7;

  // memory access counts
  localparam logic [MACC_W-1:0] MACC_NONE    = 2'd0;
  localparam logic [MACC_W-1:0] MACC_FILL    = 2'd1;
  localparam logic [MACC_W-1:0] MACC_FILL_WB = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS = 2'd0,
    CFG_OFF_BITS = 2'd1,
    CFG_WAYS     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OC_HIT      = 2'd0,
    OC_MISS     = 2'd1,
    OC_BAD_SIZE = 2'd2,
    OC_MISALIGN = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // decoded reference, held while the set is looked up
  typedef struct packed {
    logic              legal;
    outcome_t          err;
    logic              is_write;
    logic [OFF_W-1:0]  line_off;
  } dec_t;

  // way logic verdict
  typedef struct packed {
    logic              hit;
    logic [MACC_W-1:0] mem_acc;
  } upd_t;

endpackage

FILE: hw/rtl/slwc_channels.sv
// ----------------------------------------------------------------------------
// slwc channels - valid/ready interfaces
// Reference input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface slwc_in_if;
  logic                                valid;
  logic                                ready;
  logic [slwc_pkg::ADDR_FIELD_W-1:0]   address;
  logic                                is_write;
  logic [slwc_pkg::SIZE_W-1:0]         access_size;

  modport source (output valid, address, is_write, access_size, input ready);
  modport sink   (input valid, address, is_write, access_size, output ready);
endinterface

interface slwc_out_if;
  logic                                valid;
  logic                                ready;
  slwc_pkg::outcome_t                  outcome;
  logic [slwc_pkg::MACC_W-1:0]         memory_accesses;
  logic [slwc_pkg::TAG_FIELD_W-1:0]    tag_field;
  logic [slwc_pkg::SET_FIELD_W-1:0]    set_number;
  logic [slwc_pkg::OFF_W-1:0]          line_offset;
  logic [slwc_pkg::HITS_W-1:0]         hits_so_far;

  modport source (output valid, outcome, memory_accesses, tag_field, set_number,
                  line_offset, hits_so_far, input ready);
  modport sink   (input valid, outcome, memory_accesses, tag_field, set_number,
                  line_offset, hits_so_far, output ready);
endinterface

interface slwc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [slwc_pkg::CFG_IDX_W-1:0]      index;
  logic [slwc_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/slwc_set_ram.sv
// ----------------------------------------------------------------------------
// slwc_set_ram - set memory
// One row per set holding tag, rank, dirty and valid of every way.
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module slwc_set_ram #(
  parameter int ROW_W  = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ROW_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ROW_W-1:0]  wr_data
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/slwc_addr_split.sv
// ----------------------------------------------------------------------------
// slwc_addr_split - reference decode
// Splits the address into tag, set and offset and checks size and alignment.
// ----------------------------------------------------------------------------
module slwc_addr_split #(
  parameter int TAG_W = 32,
  parameter int SET_W = 10
) (
  input  logic [TAG_W-1:0]             addr,
  input  logic                         is_write,
  input  logic [slwc_pkg::SIZE_W-1:0]  access_size,
  input  logic [slwc_pkg::SHIFT_W-1:0] set_bits,
  input  logic [3:0]                   off_bits,
  output logic [TAG_W-1:0]             tag,
  output logic [SET_W-1:0]             set_idx,
  output slwc_pkg::dec_t               dec
);

  logic [slwc_pkg::SHIFT_W-1:0] tag_sh;
  logic [TAG_W-1:0]             above_off;
  logic [slwc_pkg::OFF_W-1:0]   off;
  logic                         size_ok;
  logic [2:0]                   size_m1;
  logic                         misalign;
  logic [9:0]                   end_byte;
  logic [9:0]                   line_bytes;

  always_comb begin
    tag_sh    = set_bits + slwc_pkg::SHIFT_W'(off_bits);
    tag       = addr >> tag_sh;
    above_off = addr >> off_bits;
    set_idx   = above_off[SET_W-1:0] & ~({SET_W{1'b1}} << set_bits);
    off       = addr[slwc_pkg::OFF_W-1:0] & ~(8'hFF << off_bits);

    size_ok    = (access_size == 8'd1) || (access_size == 8'd2) ||
                 (access_size == 8'd4) || (access_size == 8'd8);
    size_m1    = access_size[2:0] - 3'd1;
    end_byte   = {2'b00, off} + {2'b00, access_size};
    line_bytes = 10'd1 << off_bits;
    misalign   = ((addr[2:0] & size_m1) != 3'd0) || (end_byte > line_bytes);

    dec.is_write = is_write;
    dec.line_off = off;
    dec.legal    = size_ok && !misalign;
    dec.err      = size_ok ? slwc_pkg::OC_MISALIGN : slwc_pkg::OC_BAD_SIZE;
  end

endmodule

FILE: hw/rtl/slwc_way_update.sv
// ----------------------------------------------------------------------------
// slwc_way_update - way compare and replacement
// Parallel tag match over the set, victim choice (first free, else oldest),
// recency rank update and new row contents.
// ----------------------------------------------------------------------------
module slwc_way_update #(
  parameter int MAX_WAYS = 8,
  parameter int TAG_W    = 32
) (
  input  logic [MAX_WAYS-1:0][TAG_W-1:0]            tags_i,
  input  logic [MAX_WAYS-1:0][slwc_pkg::RANK_W-1:0] ranks_i,
  input  logic [MAX_WAYS-1:0]                       dirty_i,
  input  logic [MAX_WAYS-1:0]                       valid_i,
  input  logic [TAG_W-1:0]                          req_tag,
  input  logic                                      req_wr,
  input  logic [slwc_pkg::WAYS_W-1:0]               ways,
  output logic [MAX_WAYS-1:0][TAG_W-1:0]            tags_o,
  output logic [MAX_WAYS-1:0][slwc_pkg::RANK_W-1:0] ranks_o,
  output logic [MAX_WAYS-1:0]                       dirty_o,
  output logic [MAX_WAYS-1:0]                       valid_o,
  output slwc_pkg::upd_t                            upd
);

  localparam int WI_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic                          hit;
  logic [WI_W-1:0]               hit_way;
  logic                          free;
  logic [WI_W-1:0]               free_way;
  logic [WI_W-1:0]               lru_way;
  logic [slwc_pkg::RANK_W-1:0]   best;
  logic [WI_W-1:0]               way_sel;
  logic                          was_valid;
  logic [slwc_pkg::RANK_W-1:0]   old_rank;

  // match, free way and oldest way
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    lru_way  = '0;
    best     = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (slwc_pkg::WAYS_W'(i) < ways) begin
        if (!hit && valid_i[i] && (tags_i[i] == req_tag)) begin
          hit     = 1'b1;
          hit_way = WI_W'(i);
        end
        if (!free && !valid_i[i]) begin
          free     = 1'b1;
          free_way = WI_W'(i);
        end
        if (i == 0) begin
          best = ranks_i[i];
        end else if (ranks_i[i] > best) begin
          best    = ranks_i[i];
          lru_way = WI_W'(i);
        end
      end
    end
  end

  // new row
  always_comb begin
    way_sel   = hit ? hit_way : (free ? free_way : lru_way);
    was_valid = valid_i[way_sel];
    old_rank  = ranks_i[way_sel];
    tags_o    = tags_i;
    ranks_o   = ranks_i;
    dirty_o   = dirty_i;
    valid_o   = valid_i;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if ((slwc_pkg::WAYS_W'(i) < ways) && (WI_W'(i) != way_sel) && valid_i[i] &&
          (!was_valid || (ranks_i[i] < old_rank)) && (ranks_i[i] != slwc_pkg::RANK_TOP)) begin
        ranks_o[i] = ranks_i[i] + 3'd1;
      end
    end
    ranks_o[way_sel] = '0;
    if (hit) begin
      dirty_o[way_sel] = dirty_i[way_sel] | req_wr;
    end else begin
      valid_o[way_sel] = 1'b1;
      dirty_o[way_sel] = req_wr;
      tags_o[way_sel]  = req_tag;
    end

    upd.hit = hit;
    if (hit) begin
      upd.mem_acc = slwc_pkg::MACC_NONE;
    end else if (was_valid && dirty_i[way_sel]) begin
      upd.mem_acc = slwc_pkg::MACC_FILL_WB;
    end else begin
      upd.mem_acc = slwc_pkg::MACC_FILL;
    end
  end

endmodule

FILE: hw/rtl/set_assoc_lru_writeback_cache.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache - tag model of a write-back LRU cache
// Set-associative, write-allocate cache directory: hit/miss, write-backs
// and running hit count for each memory reference.
// ----------------------------------------------------------------------------
//
//  channel  | dir | words carried
//  ---------+-----+-----------------------------------------------------------
//  in_ch    | in  | address, is_write, access_size
//  out_ch   | out | outcome, memory_accesses, tag_field, set_number,
//           |     | line_offset, hits_so_far
//  cfg_ch   | in  | index (0 set bits, 1 offset bits, 2 ways), data
//
//  For each reference the set row is read from the set RAM in the accept cycle,
//  then compared, updated and written back in the next, which also loads the
//  result register. in_ch is held not ready during this read-modify-write of
//  the set row; the next word is read only after the write-back.
//  After reset a clearing pass zeroes every row of the set RAM; in_ch is held
//  not ready meanwhile, cfg_ch is always ready.
//  A stalled result waits in the output register; a new word is accepted in
//  the cycle that result is taken.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache #(
  parameter int MAX_SET_BITS = slwc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = slwc_pkg::MAX_WAYS_DEF,
  parameter int ADDRESS_BITS = slwc_pkg::ADDRESS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  slwc_in_if.sink     in_ch,
  slwc_out_if.source  out_ch,
  slwc_cfg_if.sink    cfg_ch
);

  // the address word is 32 bits wide; narrower address spaces mask it
  localparam int TAG_W     = (ADDRESS_BITS < slwc_pkg::ADDR_FIELD_W) ?
                             ADDRESS_BITS : slwc_pkg::ADDR_FIELD_W;
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int DEPTH     = 1 << MAX_SET_BITS;
  localparam int WAY_ROW_W = TAG_W + slwc_pkg::RANK_W + 2;
  localparam int ROW_W     = MAX_WAYS * WAY_ROW_W;
  localparam logic [SET_W-1:0] LAST_ROW = SET_W'(DEPTH - 1);

  // configuration
  logic [slwc_pkg::CFG_DATA_W-1:0] set_bits_r, off_bits_r, ways_r;
  logic [slwc_pkg::SHIFT_W-1:0]    set_bits_c;
  logic [3:0]                      off_bits_c;
  logic [slwc_pkg::WAYS_W-1:0]     ways_c;

  // control
  slwc_pkg::state_t state_r, state_nxt;
  logic [SET_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             in_fire;
  logic             lookup;
  logic             out_valid_r, out_valid_nxt;
  logic [slwc_pkg::HITS_W-1:0] hit_cnt_r, hit_cnt_nxt;

  // request path
  logic [TAG_W-1:0] dec_tag;
  logic [SET_W-1:0] dec_set;
  slwc_pkg::dec_t   dec;
  logic [TAG_W-1:0] req_tag_r;
  logic [SET_W-1:0] req_set_r;
  slwc_pkg::dec_t   req_r;

  // set RAM
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] row_new;

  logic [MAX_WAYS-1:0][TAG_W-1:0]            tags_rd, tags_wr;
  logic [MAX_WAYS-1:0][slwc_pkg::RANK_W-1:0] ranks_rd, ranks_wr;
  logic [MAX_WAYS-1:0]                       dirty_rd, dirty_wr;
  logic [MAX_WAYS-1:0]                       valid_rd, valid_wr;
  slwc_pkg::upd_t                            upd;

  // result register
  slwc_pkg::outcome_t               outcome_r;
  logic [slwc_pkg::MACC_W-1:0]      macc_r;
  logic [slwc_pkg::TAG_FIELD_W-1:0] tag_out_r;
  logic [slwc_pkg::SET_FIELD_W-1:0] set_out_r;
  logic [slwc_pkg::OFF_W-1:0]       off_out_r;
  logic [slwc_pkg::HITS_W-1:0]      hits_out_r;

  // ---- configuration registers; out-of-range values clamp on use ----
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= slwc_pkg::SET_BITS_RST;
      off_bits_r <= slwc_pkg::OFF_BITS_RST;
      ways_r     <= slwc_pkg::WAYS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        slwc_pkg::CFG_SET_BITS: set_bits_r <= cfg_ch.data;
        slwc_pkg::CFG_OFF_BITS: off_bits_r <= cfg_ch.data;
        slwc_pkg::CFG_WAYS:     ways_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    set_bits_c = ({1'b0, set_bits_r} > slwc_pkg::SHIFT_W'(MAX_SET_BITS)) ?
                 slwc_pkg::SHIFT_W'(MAX_SET_BITS) : {1'b0, set_bits_r};
    off_bits_c = (off_bits_r > 4'(slwc_pkg::LINE_BITS_TOP)) ?
                 4'(slwc_pkg::LINE_BITS_TOP) : off_bits_r;
    if (ways_r == '0) begin
      ways_c = slwc_pkg::WAYS_W'(1);
    end else if ({1'b0, ways_r} > slwc_pkg::WAYS_W'(MAX_WAYS)) begin
      ways_c = slwc_pkg::WAYS_W'(MAX_WAYS);
    end else begin
      ways_c = {1'b0, ways_r};
    end
  end

  // ---- decode of the incoming word ----
  slwc_addr_split #(
    .TAG_W (TAG_W),
    .SET_W (SET_W)
  ) u_split (
    .addr        (in_ch.address[TAG_W-1:0]),
    .is_write    (in_ch.is_write),
    .access_size (in_ch.access_size),
    .set_bits    (set_bits_c),
    .off_bits    (off_bits_c),
    .tag         (dec_tag),
    .set_idx     (dec_set),
    .dec         (dec)
  );

  // ---- sequencer ----
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      slwc_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ROW) begin
          state_nxt = slwc_pkg::ST_IDLE;
        end
      end
      slwc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = slwc_pkg::ST_LOOKUP;
        end
      end
      slwc_pkg::ST_LOOKUP: state_nxt = slwc_pkg::ST_IDLE;
      default:             state_nxt = slwc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    lookup      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = req_set_r;
    ram_wdata   = row_new;
    case (state_r)
      slwc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      slwc_pkg::ST_IDLE: begin
        // result slot frees up at this edge if it is being taken
        in_ch.ready = !out_valid_r || out_ch.ready;
      end
      slwc_pkg::ST_LOOKUP: begin
        lookup = 1'b1;
        ram_we = req_r.legal;
      end
      default: ;
    endcase
  end

  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= slwc_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // ---- request hold ----
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_tag_r <= dec_tag;
      req_set_r <= dec_set;
      req_r     <= dec;
    end
  end

  // ---- set RAM and way logic ----
  slwc_set_ram #(
    .ROW_W  (ROW_W),
    .DEPTH  (DEPTH),
    .ADDR_W (SET_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (dec_set),
    .rd_data (ram_rdata),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata)
  );

  assign {tags_rd, ranks_rd, dirty_rd, valid_rd} = ram_rdata;
  assign row_new = {tags_wr, ranks_wr, dirty_wr, valid_wr};

  slwc_way_update #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W)
  ) u_upd (
    .tags_i  (tags_rd),
    .ranks_i (ranks_rd),
    .dirty_i (dirty_rd),
    .valid_i (valid_rd),
    .req_tag (req_tag_r),
    .req_wr  (req_r.is_write),
    .ways    (ways_c),
    .tags_o  (tags_wr),
    .ranks_o (ranks_wr),
    .dirty_o (dirty_wr),
    .valid_o (valid_wr),
    .upd     (upd)
  );

  // ---- hit count and result register ----
  always_comb begin
    hit_cnt_nxt = hit_cnt_r;
    if (lookup && req_r.legal && upd.hit) begin
      hit_cnt_nxt = hit_cnt_r + 1'b1;
    end
    if (lookup) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hit_cnt_r   <= hit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup) begin
      if (req_r.legal) begin
        outcome_r <= upd.hit ? slwc_pkg::OC_HIT : slwc_pkg::OC_MISS;
        macc_r    <= upd.mem_acc;
      end else begin
        outcome_r <= req_r.err;
        macc_r    <= slwc_pkg::MACC_NONE;
      end
      tag_out_r  <= slwc_pkg::TAG_FIELD_W'(req_tag_r);
      set_out_r  <= slwc_pkg::SET_FIELD_W'(req_set_r);
      off_out_r  <= req_r.line_off;
      hits_out_r <= hit_cnt_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.outcome         = outcome_r;
  assign out_ch.memory_accesses = macc_r;
  assign out_ch.tag_field       = tag_out_r;
  assign out_ch.set_number      = set_out_r;
  assign out_ch.line_offset     = off_out_r;
  assign out_ch.hits_so_far     = hits_out_r;

endmodule

FILE: bench/set_assoc_lru_writeback_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_tb - self-checking bench for the cache tag model
// Drives memory references and register writes over valid/ready channels with
// random gaps and stalls. A behavioural copy of the directory (tags, valid,
// dirty, recency ranks, hit count) predicts every result word, which is then
// compared field by field with what the block returns.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache_tb;

  localparam int SETS_TOTAL  = 1 << slwc_pkg::MAX_SET_BITS_DEF;
  localparam int SLOTS_TOTAL = SETS_TOTAL * slwc_pkg::MAX_WAYS_DEF;
  localparam int PHASE_REFS  = 153;
  localparam int SHOW_MAX    = 10;

  // one predicted result word
  typedef struct packed {
    slwc_pkg::outcome_t                   oc;
    logic [slwc_pkg::MACC_W-1:0]          macc;
    logic [slwc_pkg::TAG_FIELD_W-1:0]     tag;
    logic [slwc_pkg::SET_FIELD_W-1:0]     set_no;
    logic [slwc_pkg::OFF_W-1:0]           off;
    logic [slwc_pkg::HITS_W-1:0]          hits;
  } cache_verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  slwc_in_if  in_ch ();
  slwc_out_if out_ch ();
  slwc_cfg_if cfg_ch ();

  set_assoc_lru_writeback_cache dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow directory: our own copy of the cache contents and registers
  // --------------------------------------------------------------------------
  bit [31:0]                 dir_tag   [SLOTS_TOTAL];
  bit                        dir_valid [SLOTS_TOTAL];
  bit                        dir_dirty [SLOTS_TOTAL];
  bit [slwc_pkg::RANK_W-1:0] dir_rank  [SLOTS_TOTAL];
  bit [31:0]                 hit_count = '0;

  logic [slwc_pkg::CFG_DATA_W-1:0] reg_set_bits = slwc_pkg::SET_BITS_RST;
  logic [slwc_pkg::CFG_DATA_W-1:0] reg_off_bits = slwc_pkg::OFF_BITS_RST;
  logic [slwc_pkg::CFG_DATA_W-1:0] reg_ways     = slwc_pkg::WAYS_RST;

  cache_verdict_t verdicts_due[$];

  // run statistics
  int refs_sent   = 0;
  int words_seen  = 0;
  int hits_seen   = 0;
  int misses_seen = 0;
  int wb_seen     = 0;
  int rejects     = 0;
  int settings    = 0;
  int mismatches  = 0;

  // idling limits, changed per phase (0 = no idling on that side)
  int src_gap_max  = 0;
  int sink_gap_max = 0;
  int sink_hold    = 0;

  // geometry after clamping of out-of-range register values
  function automatic int unsigned eff_set_bits();
    return (reg_set_bits > slwc_pkg::MAX_SET_BITS_DEF) ? slwc_pkg::MAX_SET_BITS_DEF :
                                                         reg_set_bits;
  endfunction

  function automatic int unsigned eff_off_bits();
    return (reg_off_bits > slwc_pkg::LINE_BITS_TOP) ? slwc_pkg::LINE_BITS_TOP : reg_off_bits;
  endfunction

  function automatic int unsigned eff_ways();
    if (reg_ways == 0) return 1;
    return (reg_ways > slwc_pkg::MAX_WAYS_DEF) ? slwc_pkg::MAX_WAYS_DEF : reg_ways;
  endfunction

  // make way w most recent; valid ways more recent than w (all valid ways if w was invalid) age by one, saturating
  function automatic void promote_way(int unsigned base, int unsigned nways,
                                      int unsigned w, bit was_valid);
    bit [slwc_pkg::RANK_W-1:0] old;
    int unsigned s;
    old = dir_rank[base + w];
    for (int unsigned i = 0; i < nways; i++) begin
      s = base + i;
      if (i == w || !dir_valid[s]) continue;
      if (!was_valid || dir_rank[s] < old) begin
        if (dir_rank[s] < slwc_pkg::RANK_TOP) dir_rank[s] = dir_rank[s] + 1'b1;
      end
    end
    dir_rank[base + w] = '0;
  endfunction

  // work out the result word of one reference and update the shadow directory
  function automatic cache_verdict_t lookup_reference(logic [31:0] addr, logic wr,
                                                      logic [7:0] size);
    cache_verdict_t v;
    int unsigned ib, ob, nways, base, w;
    logic [63:0] a64, tag, setn, off;
    bit hit, found_free;
    bit [slwc_pkg::RANK_W-1:0] best;
    ib    = eff_set_bits();
    ob    = eff_off_bits();
    nways = eff_ways();
    a64   = {32'd0, addr};
    tag   = a64 >> (ib + ob);
    setn  = (a64 >> ob) & ((64'd1 << ib) - 64'd1);
    off   = a64 & ((64'd1 << ob) - 64'd1);
    v.macc = slwc_pkg::MACC_NONE;
    if (size != 8'd1 && size != 8'd2 && size != 8'd4 && size != 8'd8) begin
      v.oc = slwc_pkg::OC_BAD_SIZE;
    end else if ((a64 & ({56'd0, size} - 64'd1)) != 0 ||
                 {56'd0, size} + off > (64'd1 << ob)) begin
      v.oc = slwc_pkg::OC_MISALIGN;
    end else begin
      base = setn[slwc_pkg::SET_FIELD_W-1:0] * slwc_pkg::MAX_WAYS_DEF;
      hit  = 1'b0;
      w    = 0;
      for (int unsigned i = 0; i < nways; i++) begin
        if (!hit && dir_valid[base + i] && dir_tag[base + i] == tag[31:0]) begin
          hit = 1'b1;
          w   = i;
        end
      end
      if (hit) begin
        v.oc = slwc_pkg::OC_HIT;
        hit_count++;
        promote_way(base, nways, w, 1'b1);
        if (wr) dir_dirty[base + w] = 1'b1;
      end else begin
        v.oc       = slwc_pkg::OC_MISS;
        v.macc     = slwc_pkg::MACC_FILL;
        found_free = 1'b0;
        for (int unsigned i = 0; i < nways; i++) begin
          if (!found_free && !dir_valid[base + i]) begin
            found_free = 1'b1;
            w          = i;
          end
        end
        // victim: lowest way holding the largest rank
        if (!found_free) begin
          best = dir_rank[base];
          for (int unsigned i = 1; i < nways; i++) begin
            if (dir_rank[base + i] > best) begin
              best = dir_rank[base + i];
              w    = i;
            end
          end
        end
        if (dir_valid[base + w] && dir_dirty[base + w]) v.macc = slwc_pkg::MACC_FILL_WB;
        promote_way(base, nways, w, dir_valid[base + w]);
        dir_valid[base + w] = 1'b1;
        dir_dirty[base + w] = wr;
        dir_tag[base + w]   = tag[31:0];
      end
    end
    v.tag    = tag[31:0];
    v.set_no = setn[slwc_pkg::SET_FIELD_W-1:0];
    v.off    = off[slwc_pkg::OFF_W-1:0];
    v.hits   = hit_count;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // send one reference word; prediction is made at the accepting edge
  task automatic send_ref(logic [31:0] addr, logic wr, logic [7:0] size);
    int gap;
    cache_verdict_t pred;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.address     <= addr;
    in_ch.is_write    <= wr;
    in_ch.access_size <= size;
    do @(posedge clk); while (!in_ch.ready);
    pred = lookup_reference(addr, wr, size);
    verdicts_due = {verdicts_due, pred};
    refs_sent++;
  endtask

  // drop valid and wait for every outstanding word, plus the block's latency
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(slwc_pkg::cfg_reg_t idx,
                                logic [slwc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      slwc_pkg::CFG_SET_BITS: reg_set_bits = val;
      slwc_pkg::CFG_OFF_BITS: reg_off_bits = val;
      slwc_pkg::CFG_WAYS:     reg_ways     = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // new geometry; only called with the block idle
  task automatic set_geometry(logic [3:0] sb, logic [3:0] ob, logic [3:0] nw);
    settle();
    write_register(slwc_pkg::CFG_SET_BITS, sb);
    write_register(slwc_pkg::CFG_OFF_BITS, ob);
    write_register(slwc_pkg::CFG_WAYS, nw);
    settings++;
  endtask

  // result sink: random stall drawn after each word taken
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_ch.ready <= 1'b0;
      sink_hold--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result checker: compare each word with the oldest prediction
  always @(posedge clk) begin
    cache_verdict_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.oc     = out_ch.outcome;
      got.macc   = out_ch.memory_accesses;
      got.tag    = out_ch.tag_field;
      got.set_no = out_ch.set_number;
      got.off    = out_ch.line_offset;
      got.hits   = out_ch.hits_so_far;
      words_seen++;
      case (got.oc)
        slwc_pkg::OC_HIT:  hits_seen++;
        slwc_pkg::OC_MISS: misses_seen++;
        default: rejects++;
      endcase
      if (got.macc == slwc_pkg::MACC_FILL_WB) wb_seen++;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("[%0t] unexpected word: oc=%0d macc=%0d tag=%h set=%0d off=%0d hits=%0d",
                   $realtime, got.oc, got.macc, got.tag, got.set_no, got.off, got.hits);
      end else begin
        want = verdicts_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= SHOW_MAX) begin
            $display("[%0t] mismatch on word %0d", $realtime, words_seen);
            $display("  expected oc=%0d macc=%0d tag=%h set=%0d off=%0d hits=%0d",
                     want.oc, want.macc, want.tag, want.set_no, want.off, want.hits);
            $display("  actual   oc=%0d macc=%0d tag=%h set=%0d off=%0d hits=%0d",
                     got.oc, got.macc, got.tag, got.set_no, got.off, got.hits);
          end
        end
      end
      sink_hold = $urandom_range(0, sink_gap_max);
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset geometry: one set, 8-byte lines, direct mapped
  task automatic test_reset_geometry();
    settings++;
    send_ref(32'h0000_0000, 1'b0, 8'd1);   // cold miss
    send_ref(32'h0000_0004, 1'b0, 8'd4);   // same line, hit
    send_ref(32'h0000_0000, 1'b1, 8'd8);   // write hit, line now dirty
    send_ref(32'h0000_0008, 1'b0, 8'd8);   // conflict, dirty victim written back
    send_ref(32'h0000_0000, 1'b0, 8'd3);   // illegal size
    send_ref(32'hFFFF_FFFF, 1'b1, 8'd0);
    send_ref(32'h0000_0000, 1'b0, 8'd255);
    send_ref(32'h0000_0002, 1'b0, 8'd4);   // misaligned
    send_ref(32'hFFFF_FFF8, 1'b1, 8'd8);   // clean victim
  endtask

  // largest geometry, then one-byte lines
  task automatic test_geometry_extremes();
    set_geometry(4'd10, 4'd8, 4'd8);
    send_ref(32'hFFFF_FFFF, 1'b1, 8'd1);
    send_ref(32'hFFFF_FFF8, 1'b0, 8'd8);
    set_geometry(4'd10, 4'd0, 4'd8);
    send_ref(32'h0000_0010, 1'b0, 8'd2);   // aligned but wider than the line
    send_ref(32'h0000_0010, 1'b1, 8'd1);
    send_ref(32'h0000_0010, 1'b0, 8'd1);
  endtask

  // out-of-range register values are clamped
  task automatic test_register_clamp();
    set_geometry(4'd15, 4'd15, 4'd0);
    send_ref(32'h0003_FF00, 1'b0, 8'd4);
    send_ref(32'h1234_5678, 1'b1, 8'd8);
    set_geometry(4'd15, 4'd15, 4'd15);
    send_ref(32'hFFFF_FFFC, 1'b1, 8'd4);
  endtask

  // two sets of two ways, 4-byte lines: LRU order, write-back, way shrink
  task automatic test_lru_eviction();
    set_geometry(4'd1, 4'd2, 4'd2);
    send_ref(32'h0000_0000, 1'b1, 8'd4);   // tag 0, dirty
    send_ref(32'h0000_0008, 1'b0, 8'd4);   // tag 1 into the free way
    send_ref(32'h0000_0000, 1'b0, 8'd2);   // tag 0 most recent again
    send_ref(32'h0000_0010, 1'b0, 8'd1);   // tag 2 evicts clean tag 1
    send_ref(32'h0000_0008, 1'b0, 8'd4);   // tag 1 evicts dirty tag 0
    send_ref(32'h0000_0000, 1'b0, 8'd8);   // crosses the 4-byte line
    set_geometry(4'd1, 4'd2, 4'd1);        // contents kept, way 1 ignored
    send_ref(32'h0000_0010, 1'b0, 8'd4);
  endtask

  // random phase: mostly well-formed references into a few sets from a small
  // tag pool, so hits, LRU evictions and write-backs are frequent
  task automatic test_random_phase(logic [3:0] sb, logic [3:0] ob, logic [3:0] nw,
                                   int src_max, int sink_max);
    bit [31:0] tag_pool[10];
    int unsigned ib, obe, npool, kind, line, setsel;
    logic [7:0] size;
    logic [63:0] a64;
    set_geometry(sb, ob, nw);
    src_gap_max  = src_max;
    sink_gap_max = sink_max;
    ib    = eff_set_bits();
    obe   = eff_off_bits();
    npool = eff_ways() + 2;
    line  = 1 << obe;
    foreach (tag_pool[i]) tag_pool[i] = $urandom;
    for (int n = 0; n < PHASE_REFS; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        size   = 8'd1 << $urandom_range(0, 3);
        setsel = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3);
        a64    = ({32'd0, tag_pool[$urandom_range(0, npool - 1)]} << (ib + obe)) |
                 ((64'(setsel) & ((64'd1 << ib) - 64'd1)) << obe) |
                 (64'($urandom & (line - 1)) & ~(64'(size) - 64'd1));
        send_ref(a64[31:0], 1'($urandom_range(0, 1)), size);
      end else if (kind < 90) begin
        send_ref($urandom, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        // random address, legal size: mostly misaligned
        send_ref($urandom, 1'($urandom_range(0, 1)), 8'd1 << $urandom_range(1, 3));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.address     = '0;
    in_ch.is_write    = 1'b0;
    in_ch.access_size = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = slwc_pkg::CFG_SET_BITS;
    cfg_ch.data       = '0;
    foreach (dir_valid[i]) begin
      dir_tag[i]   = '0;
      dir_valid[i] = 1'b0;
      dir_dirty[i] = 1'b0;
      dir_rank[i]  = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part with no idling, then with full idling on both sides, then with no idling again
    test_reset_geometry();
    src_gap_max  = 7;
    sink_gap_max = 7;
    test_geometry_extremes();
    test_register_clamp();
    src_gap_max  = 0;
    sink_gap_max = 0;
    test_lru_eviction();

    // random part over several geometries, extremes included
    test_random_phase(4'd0,  4'd3,  4'd1,  7, 7);
    test_random_phase(4'd0,  4'd0,  4'd1,  0, 0);
    test_random_phase(4'd10, 4'd8,  4'd8,  7, 0);
    test_random_phase(4'd2,  4'd2,  4'd4,  0, 7);
    test_random_phase(4'd15, 4'd15, 4'd0,  3, 3);
    test_random_phase(4'd15, 4'd15, 4'd15, 7, 7);
    test_random_phase(4'd1,  4'd1,  4'd3,  0, 0);
    test_random_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), 7, 7);
    test_random_phase(4'd3,  4'd4,  4'd2,  7, 7);

    settle();
    repeat (10) @(posedge clk);

    $display("Checked %0d of %0d references over %0d register settings", words_seen,
             refs_sent, settings);
    $display("  %0d hits, %0d misses (%0d with write-back), %0d rejected, %0d mismatches",
             hits_seen, misses_seen, wb_seen, rejects, mismatches);
    if (mismatches == 0 && verdicts_due.size() == 0 && words_seen == refs_sent) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run (clearing pass plus
  // ~1400 words at worst-case gaps and stalls)
  initial begin
    #2ms;
    $display("watchdog expired with %0d words outstanding", verdicts_due.size());
    $display("FAIL");
    $finish;
  end

endmodule
